FILE: rtl/cfc_pkg.sv
package cfc_pkg;

   localparam int MAX_FRAME_DEF = 253;
   localparam int RSP_MAX       = 3;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SYNC = 2'd1;
   localparam logic [1:0] ST_OVFL = 2'd2;

   typedef struct packed {
      logic [7:0] position;
      logic [7:0] value;
      logic [1:0] status;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [RSP_MAX-1:0]       rsp;
   } batch_type;

endpackage

FILE: rtl/cobs_frame_codec_unit.sv
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | req_data_byte, req_last_of_frame
// rsp     | out       | rsp_valid / rsp_ready  | rsp_position, rsp_value, rsp_status,
//         |           |                        | rsp_frame_end
// csr     | in        | csr_valid / csr_ready  | csr_direction_mode
//
// One request per cycle while req_ready holds; each yields zero to three responses,
// one per cycle while rsp_ready is high. Responses leave through a four-entry queue;
// a request waits until the queue can take its full batch; responses set the pace.
// Synchronous reset clears the frame state, the queue and selects encode mode.
// A csr write is always taken and restarts the frame.
module cobs_frame_codec_unit #(
   parameter int MAX_FRAME = cfc_pkg::MAX_FRAME_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_position,
   output logic [7:0] rsp_value,
   output logic [1:0] rsp_status,
   output logic       rsp_frame_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_direction_mode
);

   cfc_pkg::batch_type batch;
   cfc_pkg::rsp_type   rsp_head;
   logic               space_ok;
   logic               req_accept;

   assign req_ready  = space_ok;
   assign req_accept = req_valid && space_ok;
   assign csr_ready  = 1'b1;

   cfc_core #(
      .MAX_FRAME(MAX_FRAME)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .req_accept(req_accept),
      .data_byte(req_data_byte),
      .last_of_frame(req_last_of_frame),
      .csr_write(csr_valid),
      .csr_mode(csr_direction_mode),
      .batch(batch)
   );

   cfc_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(req_accept),
      .batch(batch),
      .space_ok(space_ok),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_head(rsp_head)
   );

   assign rsp_position  = rsp_head.position;
   assign rsp_value     = rsp_head.value;
   assign rsp_status    = rsp_head.status;
   assign rsp_frame_end = rsp_head.frame_end;

endmodule

FILE: rtl/cfc_core.sv
module cfc_core #(
   parameter int MAX_FRAME = cfc_pkg::MAX_FRAME_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic [7:0]           data_byte,
   input  logic                 last_of_frame,
   input  logic                 csr_write,
   input  logic                 csr_mode,
   output cfc_pkg::batch_type   batch
);

   localparam logic [8:0] MaxPos  = 9'(MAX_FRAME);
   localparam logic [7:0] OvflPos = 8'(MAX_FRAME + 1);

   logic       mode_ff;
   logic [7:0] code_pos_ff, code_pos_in;
   logic [7:0] run_len_ff, run_len_in;
   logic [7:0] byte_pos_ff, byte_pos_in;
   logic       discard_ff, discard_in;
   logic [8:0] enc_pos;
   logic [7:0] enc_pos8;
   logic       zero_byte;

   assign enc_pos   = {1'b0, byte_pos_ff} + 9'd1;
   assign enc_pos8  = enc_pos[7:0];
   assign zero_byte = (data_byte == 8'd0);

   always_comb begin
      code_pos_in = code_pos_ff;
      run_len_in  = run_len_ff;
      byte_pos_in = byte_pos_ff;
      discard_in  = discard_ff;
      batch       = '0;
      if (mode_ff == cfc_pkg::MODE_ENCODE) begin
         if (discard_ff) begin
            if (last_of_frame) begin
               code_pos_in = '0;
               run_len_in  = 8'd1;
               byte_pos_in = '0;
               discard_in  = 1'b0;
            end
         end else if (enc_pos > MaxPos) begin
            batch.count  = 2'd1;
            batch.rsp[0] = '{OvflPos, 8'd0, cfc_pkg::ST_OVFL, 1'b1};
            if (last_of_frame) begin
               code_pos_in = '0;
               run_len_in  = 8'd1;
               byte_pos_in = '0;
            end else begin
               discard_in = 1'b1;
            end
         end else begin
            batch.count = 2'd1;
            if (!zero_byte) begin
               batch.rsp[0] = '{enc_pos8, data_byte, cfc_pkg::ST_OK, 1'b0};
               run_len_in   = run_len_ff + 8'd1;
            end else begin
               batch.rsp[0] = '{code_pos_ff, run_len_ff, cfc_pkg::ST_OK, 1'b0};
               code_pos_in  = enc_pos8;
               run_len_in   = 8'd1;
            end
            byte_pos_in = enc_pos8;
            if (last_of_frame) begin
               batch.count  = 2'd3;
               batch.rsp[1] = '{code_pos_in, run_len_in, cfc_pkg::ST_OK, 1'b0};
               batch.rsp[2] = '{enc_pos8 + 8'd1, 8'd0, cfc_pkg::ST_OK, 1'b1};
               code_pos_in  = '0;
               run_len_in   = 8'd1;
               byte_pos_in  = '0;
            end
         end
      end else begin
         if (discard_ff) begin
            if (zero_byte) begin
               code_pos_in = '0;
               run_len_in  = 8'd1;
               byte_pos_in = '0;
               discard_in  = 1'b0;
            end
         end else if (zero_byte) begin
            batch.count = 2'd1;
            if (run_len_ff == 8'd1 && byte_pos_ff != 8'd0) begin
               batch.rsp[0] = '{byte_pos_ff, 8'd0, cfc_pkg::ST_OK, 1'b1};
            end else begin
               batch.rsp[0] = '{byte_pos_ff, 8'd0, cfc_pkg::ST_SYNC, 1'b1};
            end
            code_pos_in = '0;
            run_len_in  = 8'd1;
            byte_pos_in = '0;
         end else if ({1'b0, byte_pos_ff} > MaxPos) begin
            batch.count  = 2'd1;
            batch.rsp[0] = '{byte_pos_ff, 8'd0, cfc_pkg::ST_OVFL, 1'b1};
            discard_in   = 1'b1;
         end else begin
            batch.count = 2'd1;
            if (run_len_ff <= 8'd1) begin
               batch.rsp[0] = '{byte_pos_ff, 8'd0, cfc_pkg::ST_OK, 1'b0};
               run_len_in   = data_byte;
               code_pos_in  = byte_pos_ff;
            end else begin
               batch.rsp[0] = '{byte_pos_ff, data_byte, cfc_pkg::ST_OK, 1'b0};
               run_len_in   = run_len_ff - 8'd1;
            end
            byte_pos_in = byte_pos_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= cfc_pkg::MODE_ENCODE;
         code_pos_ff <= '0;
         run_len_ff  <= 8'd1;
         byte_pos_ff <= '0;
         discard_ff  <= 1'b0;
      end else if (csr_write) begin
         mode_ff     <= csr_mode;
         code_pos_ff <= '0;
         run_len_ff  <= 8'd1;
         byte_pos_ff <= '0;
         discard_ff  <= 1'b0;
      end else if (req_accept) begin
         code_pos_ff <= code_pos_in;
         run_len_ff  <= run_len_in;
         byte_pos_ff <= byte_pos_in;
         discard_ff  <= discard_in;
      end
   end

endmodule

FILE: rtl/cfc_rsp_queue.sv
module cfc_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cfc_pkg::batch_type   batch,
   output logic                 space_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cfc_pkg::rsp_type     rsp_head
);

   localparam int Depth = cfc_pkg::QUEUE_DEPTH;

   cfc_pkg::rsp_type q_ff [Depth];
   cfc_pkg::rsp_type q_in [Depth];
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] push_cnt;
   logic [1:0] base;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_head  = q_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign space_ok  = (cnt_ff <= 3'd1) || (cnt_ff == 3'd2 && rsp_ready);
   assign push_cnt  = push ? batch.count : 2'd0;
   assign base      = 2'(cnt_ff - {2'b00, pop});
   assign cnt_in    = cnt_ff - {2'b00, pop} + {1'b0, push_cnt};

   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         if (pop && i < Depth - 1) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      for (int k = 0; k < cfc_pkg::RSP_MAX; k++) begin
         if (2'(k) < push_cnt) begin
            q_in[2'(base + 2'(k))] = batch.rsp[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(Depth))
      else $error("response queue over depth");
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |=> rsp_valid)
      else $error("pushed response not presented");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (!pop && push_cnt == 2'd0) |=> $stable(cnt_ff))
      else $error("queue count moved without traffic");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (base <= 2'd1))
      else $error("push without room for a full batch");
`endif

endmodule
